[hw/rtl/icl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package icl_pkg;

    // sequencer states of the lookup
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_RD_A,
        ST_RD_B,
        ST_GET_B,
        ST_PREP,
        ST_MUL,
        ST_ADD,
        ST_CHK,
        ST_DIV,
        ST_SUM,
        ST_FINISH
    } t_state;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // quotient bits kept by the divider, anything larger saturates the result
    localparam int DIV_BITS = 34;
    localparam int CNT_W    = $clog2(DIV_BITS);

    localparam int KEY_W  = 32;
    localparam int DIFF_W = KEY_W + 1;
    localparam int PROD_W = 2 * DIFF_W - 1;
    localparam int SUM_W  = KEY_W + 4;

    localparam logic signed [SUM_W-1:0] RES_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] RES_MIN = -SUM_W'(64'sd2147483648);

endpackage

`default_nettype wire

[hw/rtl/icl_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module icl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[hw/rtl/inverse_curve_time_lookup.sv]
`timescale 1ns / 1ps
`default_nettype none

// Inverse curve lookup: holds up to MAX_KEYS (time, value) keys in signed Q16.16 with
// ascending values in one key RAM. A load word (tuser = 0) writes one key in the cycle it
// is accepted and gives no result. A query word (tuser = 1) binary-searches keys
// 1..n-1 for the first value not below the query, reads that key and the one before it,
// and returns tA + round((q - vA) * (tB - tA) / (vB - vA)), ties away from zero,
// saturated to 32 bits; tuser of the result is the curve valid flag, clear with time 0
// when fewer than two keys are in use. The run time of a query is set by the 34-step
// restoring divider that shares one compare-subtract unit, plus a read state and a compare
// state per search probe for the RAM's registered read. Queries that hit equal values,
// equal times, a zero offset, a saturating quotient or fewer than two keys finish early.
// The input is not ready while a query is being worked on; a result waits in the output
// register until taken.
module inverse_curve_time_lookup
    import icl_pkg::*;
#(
    parameter int MAX_KEYS = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // config: key_count
    input  wire logic         i_cfg_we,
    input  wire logic [6:0]   i_cfg_wdata,
    // input words
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // key_index[5:0], key_time[37:6], key_value[69:38], query_value[101:70], zero pad
    input  wire logic [103:0] i_s_axis_tdata,
    // mode[0]
    input  wire logic         i_s_axis_tuser,
    // result words
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // time_out[31:0]
    output logic [31:0]       o_m_axis_tdata,
    // curve_valid[0]
    output logic              o_m_axis_tuser
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int NW = $clog2(MAX_KEYS + 1);

    // input fields
    logic [5:0]              w_key_index;
    logic [KEY_W-1:0]        w_key_time;
    logic [KEY_W-1:0]        w_key_value;
    logic signed [KEY_W-1:0] w_query;
    assign w_key_index = i_s_axis_tdata[5:0];
    assign w_key_time  = i_s_axis_tdata[37:6];
    assign w_key_value = i_s_axis_tdata[69:38];
    assign w_query     = $signed(i_s_axis_tdata[101:70]);

    // registers
    t_state                   r_state, n_state;
    logic [6:0]               r_key_count;
    logic                     r_out_valid, n_out_valid;
    logic [KEY_W-1:0]         r_out_time, n_out_time;
    logic                     r_out_flag, n_out_flag;
    logic signed [KEY_W-1:0]  r_qv, n_qv;
    logic [AW-1:0]            r_first, n_first;
    logic [AW-1:0]            r_count, n_count;
    logic signed [KEY_W-1:0]  r_ta, n_ta;
    logic signed [KEY_W-1:0]  r_va, n_va;
    logic signed [KEY_W-1:0]  r_tb, n_tb;
    logic signed [KEY_W-1:0]  r_vb, n_vb;
    logic [DIFF_W-1:0]        r_a, n_a;
    logic [DIFF_W-1:0]        r_b, n_b;
    logic [DIFF_W-1:0]        r_div, n_div;
    logic                     r_neg, n_neg;
    logic [2*KEY_W-1:0]       r_prod, n_prod;
    logic [PROD_W-1:0]        r_p, n_p;
    logic                     r_sat, n_sat;
    logic [DIFF_W-1:0]        r_rem, n_rem;
    logic [DIV_BITS-1:0]      r_shift, n_shift;
    logic [CNT_W-1:0]         r_cnt, n_cnt;

    // ram ports
    logic                     w_we;
    logic [AW-1:0]            w_raddr;
    logic [2*KEY_W-1:0]       w_rdata;

    // keys in use, clipped to the store depth
    logic [NW-1:0] w_n;
    assign w_n = (32'(r_key_count) > 32'(MAX_KEYS)) ? NW'(MAX_KEYS) : NW'(r_key_count);

    logic w_accept;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_we = w_accept && (i_s_axis_tuser == MODE_LOAD)
                  && (32'(w_key_index) < 32'(MAX_KEYS));

    // value in the low half, time in the high half
    icl_ram #(
        .WIDTH (2 * KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(w_key_index)),
        .i_wdata ({w_key_time, w_key_value}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    logic [AW-1:0]            w_step;
    logic [AW-1:0]            w_mid;
    logic signed [DIFF_W-1:0] w_dv, w_num, w_dt;
    logic [DIV_BITS:0]        w_trial;
    logic [DIV_BITS:0]        w_trial_sub;
    logic [DIV_BITS:0]        w_mag;
    logic signed [SUM_W-1:0]  w_ta_x, w_mag_x, w_res;

    assign w_step = r_count >> 1;
    assign w_mid  = r_first + w_step;
    assign w_dv   = $signed({r_vb[KEY_W-1], r_vb}) - $signed({r_va[KEY_W-1], r_va});
    assign w_num  = $signed({r_qv[KEY_W-1], r_qv}) - $signed({r_va[KEY_W-1], r_va});
    assign w_dt   = $signed({r_tb[KEY_W-1], r_tb}) - $signed({r_ta[KEY_W-1], r_ta});

    // one restoring division step
    assign w_trial     = {1'b0, r_rem, r_shift[DIV_BITS-1]};
    assign w_trial_sub = w_trial - (DIV_BITS + 1)'(r_div);

    assign w_mag   = r_sat ? ((DIV_BITS + 1)'(1) << DIV_BITS) : {1'b0, r_shift};
    assign w_ta_x  = SUM_W'(r_ta);
    assign w_mag_x = $signed(SUM_W'(w_mag));
    assign w_res   = r_neg ? (w_ta_x - w_mag_x) : (w_ta_x + w_mag_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_key_count <= 7'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_key_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_time <= n_out_time;
        r_out_flag <= n_out_flag;
        r_qv       <= n_qv;
        r_first    <= n_first;
        r_count    <= n_count;
        r_ta       <= n_ta;
        r_va       <= n_va;
        r_tb       <= n_tb;
        r_vb       <= n_vb;
        r_a        <= n_a;
        r_b        <= n_b;
        r_div      <= n_div;
        r_neg      <= n_neg;
        r_prod     <= n_prod;
        r_p        <= n_p;
        r_sat      <= n_sat;
        r_rem      <= n_rem;
        r_shift    <= n_shift;
        r_cnt      <= n_cnt;
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_time  = r_out_time;
        n_out_flag  = r_out_flag;
        n_qv        = r_qv;
        n_first     = r_first;
        n_count     = r_count;
        n_ta        = r_ta;
        n_va        = r_va;
        n_tb        = r_tb;
        n_vb        = r_vb;
        n_a         = r_a;
        n_b         = r_b;
        n_div       = r_div;
        n_neg       = r_neg;
        n_prod      = r_prod;
        n_p         = r_p;
        n_sat       = r_sat;
        n_rem       = r_rem;
        n_shift     = r_shift;
        n_cnt       = r_cnt;
        w_raddr     = w_mid;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_s_axis_tuser == MODE_QUERY)) begin
                    n_qv    = w_query;
                    n_first = AW'(1);
                    n_count = AW'(w_n - NW'(2));
                    if (w_n < NW'(2)) begin
                        n_ta    = '0;
                        n_neg   = 1'b0;
                        n_sat   = 1'b0;
                        n_shift = '0;
                        n_state = ST_FINISH;
                    end else if (w_n == NW'(2)) begin
                        n_state = ST_RD_A;
                    end else begin
                        n_state = ST_SRCH_RD;
                    end
                end
            end
            ST_SRCH_RD: begin
                w_raddr = w_mid;
                n_state = ST_SRCH_CMP;
            end
            ST_SRCH_CMP: begin
                if (r_qv > $signed(w_rdata[KEY_W-1:0])) begin
                    n_first = w_mid + AW'(1);
                    n_count = r_count - w_step - AW'(1);
                end else begin
                    n_count = w_step;
                end
                n_state = (n_count == '0) ? ST_RD_A : ST_SRCH_RD;
            end
            ST_RD_A: begin
                w_raddr = r_first - AW'(1);
                n_state = ST_RD_B;
            end
            ST_RD_B: begin
                w_raddr = r_first;
                n_ta    = $signed(w_rdata[2*KEY_W-1:KEY_W]);
                n_va    = $signed(w_rdata[KEY_W-1:0]);
                n_state = ST_GET_B;
            end
            ST_GET_B: begin
                n_tb    = $signed(w_rdata[2*KEY_W-1:KEY_W]);
                n_vb    = $signed(w_rdata[KEY_W-1:0]);
                n_state = ST_PREP;
            end
            ST_PREP: begin
                // flat segment, equal times or zero offset keeps the time of key A
                if (w_dv == '0 || w_num == '0 || w_dt == '0) begin
                    n_neg   = 1'b0;
                    n_sat   = 1'b0;
                    n_shift = '0;
                    n_state = ST_SUM;
                end else begin
                    n_a     = w_num[DIFF_W-1] ? DIFF_W'(-w_num) : DIFF_W'(w_num);
                    n_b     = w_dt[DIFF_W-1] ? DIFF_W'(-w_dt) : DIFF_W'(w_dt);
                    n_div   = w_dv[DIFF_W-1] ? DIFF_W'(-w_dv) : DIFF_W'(w_dv);
                    n_neg   = w_num[DIFF_W-1] ^ w_dt[DIFF_W-1] ^ w_dv[DIFF_W-1];
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_prod  = r_a[KEY_W-1:0] * r_b[KEY_W-1:0];
                n_state = ST_ADD;
            end
            ST_ADD: begin
                // top operand bits are only set for a magnitude of exactly 2^32
                n_p = PROD_W'(r_prod)
                      + (r_a[KEY_W] ? (PROD_W'(r_b) << KEY_W) : '0)
                      + (r_b[KEY_W] ? (PROD_W'(r_a[KEY_W-1:0]) << KEY_W) : '0)
                      + PROD_W'(r_div >> 1);
                n_state = ST_ADD == r_state ? ST_CHK : r_state;
            end
            ST_CHK: begin
                n_cnt   = '0;
                n_shift = r_p[DIV_BITS-1:0];
                if (DIFF_W'(r_p[PROD_W-1:DIV_BITS]) >= r_div) begin
                    n_sat   = 1'b1;
                    n_state = ST_SUM;
                end else begin
                    n_sat   = 1'b0;
                    n_rem   = DIFF_W'(r_p[PROD_W-1:DIV_BITS]);
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_trial >= (DIV_BITS + 1)'(r_div)) begin
                    n_rem   = DIFF_W'(w_trial_sub);
                    n_shift = {r_shift[DIV_BITS-2:0], 1'b1};
                end else begin
                    n_rem   = DIFF_W'(w_trial);
                    n_shift = {r_shift[DIV_BITS-2:0], 1'b0};
                end
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_BITS - 1)) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (w_res > RES_MAX) begin
                    n_ta = $signed(RES_MAX[KEY_W-1:0]);
                end else if (w_res < RES_MIN) begin
                    n_ta = $signed(RES_MIN[KEY_W-1:0]);
                end else begin
                    n_ta = $signed(w_res[KEY_W-1:0]);
                end
                n_neg   = 1'b1;
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                // r_neg here marks a curve with two or more keys
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_time  = r_ta;
                    n_out_flag  = r_neg;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_time;
    assign o_m_axis_tuser  = r_out_flag;

`ifndef SYNTHESIS
    // search window never runs past the last key in use
    property p_search_bound;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SRCH_RD || r_state == ST_SRCH_CMP)
            |-> (32'(r_first) + 32'(r_count) + 32'd1 <= 32'(w_n));
    endproperty
    a_search_bound: assert property (p_search_bound)
        else $error("binary search left the key range");

    // divider remainder stays below the divisor
    property p_rem_bound;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_div);
    endproperty
    a_rem_bound: assert property (p_rem_bound)
        else $error("divider remainder not below divisor");

    // an accepted query always starts work and blocks the input
    property p_query_starts;
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_s_axis_tuser == MODE_QUERY)) |=> !o_s_axis_tready;
    endproperty
    a_query_starts: assert property (p_query_starts)
        else $error("query accepted but sequencer stayed idle");
`endif

endmodule

`default_nettype wire

[test/tb_inverse_curve_time_lookup.sv]
`timescale 1ns / 1ps

module tb_inverse_curve_time_lookup
    import icl_pkg::*;
();

    localparam int KEYS = 64;

    class time_lookup_scoreboard;
        typedef struct {
            logic [31:0] time_val;
            logic        valid;
        } t_time_result;

        bit [6:0]     key_count;
        int           time_tab[KEYS];
        int           value_tab[KEYS];
        t_time_result exp_times[$];
        int           errors;

        function void set_count(bit [6:0] n);
            key_count = n;
        endfunction

        function int pending();
            return exp_times.size();
        endfunction

        // lower-bound search over keys 1..n-1, then interpolate between the pair
        function int predict_time(int q, int n);
            int first, span, half, mid;
            longint ta, tb, va, vb, num, dt, dv, res;
            logic [127:0] wa, wb, wd, mag;
            bit neg;
            first = 1;
            span = n - 2;
            while (span > 0) begin
                half = span / 2;
                mid = first + half;
                if (q > value_tab[mid]) begin
                    first = mid + 1;
                    span -= half + 1;
                end else begin
                    span = half;
                end
            end
            ta = time_tab[first-1];
            tb = time_tab[first];
            va = value_tab[first-1];
            vb = value_tab[first];
            dv = vb - va;
            num = longint'(q) - va;
            dt = tb - ta;
            if (dv == 0 || num == 0 || dt == 0)
                return int'(ta);
            neg = ((num < 0) != (dt < 0)) != (dv < 0);
            wa = 128'((num < 0) ? -num : num);
            wb = 128'((dt < 0) ? -dt : dt);
            wd = 128'((dv < 0) ? -dv : dv);
            // round half away from zero on the magnitude
            mag = (wa * wb + (wd >> 1)) / wd;
            if (mag > 128'h100_0000_0000)
                mag = 128'h100_0000_0000;
            res = neg ? ta - longint'(mag) : ta + longint'(mag);
            if (res > 64'sd2147483647)
                res = 64'sd2147483647;
            if (res < -64'sd2147483648)
                res = -64'sd2147483648;
            return int'(res);
        endfunction

        function void note_input(logic mode, bit [5:0] idx, int t, int v, int q);
            t_time_result r;
            int n;
            if (mode == MODE_LOAD) begin
                time_tab[idx] = t;
                value_tab[idx] = v;
            end else begin
                n = (key_count > KEYS) ? KEYS : key_count;
                if (n < 2) begin
                    r.time_val = '0;
                    r.valid = 1'b0;
                end else begin
                    r.time_val = predict_time(q, n);
                    r.valid = 1'b1;
                end
                exp_times.push_back(r);
            end
        endfunction

        function void check_result(logic [31:0] t, logic valid);
            t_time_result r;
            if (exp_times.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got %h/%b",
                         $time, t, valid);
                errors++;
                return;
            end
            r = exp_times.pop_front();
            if (t !== r.time_val || valid !== r.valid) begin
                $display("%0t: result mismatch, expected time %h valid %b, got time %h valid %b",
                         $time, r.time_val, r.valid, t, valid);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         cfg_we;
    logic [6:0]   cfg_wdata;
    logic         s_valid;
    logic         s_ready;
    logic [103:0] s_data;
    logic         s_user;
    logic         m_valid;
    logic         m_ready;
    logic [31:0]  m_data;
    logic         m_user;

    time_lookup_scoreboard sb;
    bit steady;
    bit stall_req;
    bit key_loaded[KEYS];
    int curve_val[KEYS];

    inverse_curve_time_lookup dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic send_word(logic mode, bit [5:0] idx, int t, int v, int q);
        int gap;
        @(negedge i_clk);
        if (!steady && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            s_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid = 1'b1;
        s_user = mode;
        s_data = {2'b00, q, v, t, idx};
        do @(posedge i_clk); while (!s_ready);
        sb.note_input(mode, idx, t, v, q);
    endtask

    task automatic load_key(bit [5:0] idx, int t, int v);
        send_word(MODE_LOAD, idx, t, v, $urandom);
        key_loaded[idx] = 1'b1;
        curve_val[idx] = v;
    endtask

    task automatic query(int q);
        send_word(MODE_QUERY, 6'($urandom_range(0, 63)), $urandom, $urandom, q);
    endtask

    // wait out every expected word plus the longest query time
    task automatic drain_results();
        @(negedge i_clk);
        s_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    task automatic write_count(bit [6:0] n);
        @(negedge i_clk);
        cfg_we = 1'b1;
        cfg_wdata = n;
        @(negedge i_clk);
        cfg_we = 1'b0;
        sb.set_count(n);
    endtask

    // ascending values with random steps, some steps zero; noise gives an unordered curve
    task automatic load_curve(int m, bit noise);
        longint v;
        int tw;
        bit time_rand;
        v = longint'(int'($urandom) >>> $urandom_range(0, 12));
        tw = int'($urandom) >>> 4;
        time_rand = $urandom_range(0, 1);
        for (int i = 0; i < m; i++) begin
            if (noise)
                load_key(6'(i), $urandom, $urandom);
            else
                load_key(6'(i), time_rand ? int'($urandom) : tw, int'(v));
            v += $urandom_range(0, 32'd1 << $urandom_range(0, 22));
            if (v > 64'sd2147483647)
                v = 64'sd2147483647;
            tw += int'($urandom_range(0, 32'h0010_0000));
        end
    endtask

    function automatic int pick_query(int m);
        int i, sel;
        longint lo, hi, tmp;
        sel = $urandom_range(0, 9);
        if (sel == 9)
            return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
        if (m < 2 || sel >= 7)
            return $urandom;
        i = $urandom_range(0, m - 2);
        if (sel == 5)
            return curve_val[i+1];
        if (sel == 6)
            return curve_val[i] + ($urandom_range(0, 1) ? 1 : -1);
        lo = curve_val[i];
        hi = curve_val[i+1];
        if (lo > hi) begin
            tmp = lo;
            lo = hi;
            hi = tmp;
        end
        return int'(lo + longint'($urandom % (hi - lo + 1)));
    endfunction

    // result side: random stalls, one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_req) begin
                m_ready = 1'b0;
                repeat (399) @(negedge i_clk);
                stall_req = 1'b0;
            end else if (!steady && $urandom_range(0, 7) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 15) - 1) @(negedge i_clk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready)
            sb.check_result(m_data, m_user);
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        int counts[12];
        int m, n, idx;
        sb = new();
        counts = '{64, 2, 127, 5, 0, 64, 1, 33, 3, 64, 100, 17};
        steady = 1'b0;
        stall_req = 1'b0;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data = '0;
        s_user = MODE_LOAD;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty curve and a single key give no valid time
        query(0);
        drain_results();
        write_count(1);
        query(32'h1234_5678);
        load_key(0, 0, 0);
        load_key(1, 32'h0001_0000, 32'h0001_0000);
        drain_results();
        write_count(2);
        // on a key, inside, below and above the curve
        query(0);
        query(32'h0000_8000);
        query(-32'sh0001_0000);
        query(32'h0002_0000);
        // half-way ties round away from zero
        load_key(1, 1, 2);
        query(1);
        query(-1);
        query(3);
        // equal values, then equal times
        load_key(0, 100, 50);
        load_key(1, 900, 50);
        query(3);
        load_key(1, 100, 60);
        query(55);
        // steep segment drives the time into both rails
        load_key(0, 32'h7fff_0000, 0);
        load_key(1, 32'h7fff_ffff, 1);
        query(32'h7fff_ffff);
        query(32'h8000_0000);
        // descending values
        load_key(0, 0, 100);
        load_key(1, 1000, -100);
        query(0);

        foreach (counts[p]) begin
            drain_results();
            n = counts[p];
            m = (n > KEYS) ? KEYS : n;
            if (p >= 10)
                steady = 1'b1;
            write_count(7'(n));
            for (int i = 0; i < m; i++) begin
                if (!key_loaded[i])
                    idx = -1;
            end
            if (idx == -1 || $urandom_range(0, 1) == 0)
                load_curve(m, $urandom_range(0, 7) == 0);
            idx = 0;
            if (p == 5)
                stall_req = 1'b1;
            repeat (64) begin
                if ($urandom_range(0, 9) == 0) begin
                    idx = $urandom_range(0, 63);
                    load_key(6'(idx), $urandom,
                             ($urandom_range(0, 2) == 0) ? int'($urandom) : curve_val[idx]);
                end else begin
                    query(pick_query(m));
                end
            end
        end

        drain_results();
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
